/* design/ihm_pkg.sv */
`default_nettype none
package ihm_pkg;

   // Widths of the fixed fields of a word.
   localparam int FIELD_W = 48;
   localparam int COUNT_W = 11;
   localparam int OP_W = 2;
   localparam int STATUS_W = 3;
   localparam int SHIFT_W = 3;

   // Configuration port geometry and register map.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_HASH_SHIFT = 1'b0;
   localparam logic [SHIFT_W-1:0] HASH_SHIFT_RESET = 3'd3;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_W-1:0] OP_SET = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_FOUND = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FAIL = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0] operation;
      logic [FIELD_W-1:0] key;
      logic [FIELD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FIELD_W-1:0] result_data;
      logic [COUNT_W-1:0] entry_count;
      logic load_high;
   } rsp_type;

endpackage
`default_nettype wire

/* design/identity_hash_map_linear_probe.sv */
// A lookup or set starts at its home slot, a search at slot 0; slots are probed in order
// until the operation is decided or every slot is checked, and the result register is loaded.
// A word that fails at once (zero key on lookup or set, unknown operation) skips the probe.
// For a depth that is not a power of two the home slot is reduced one key bit a cycle.
// One word is in work at a time, reading one slot a cycle.
// Reset is synchronous; afterwards a clearing pass empties the keys.
`default_nettype none
module identity_hash_map_linear_probe #(
   parameter int TABLE_DEPTH = 1024,
   parameter int KEY_BITS = 48
) (
   input wire clock,
   input wire reset,
   input wire req_valid,
   output logic req_ready,
   input wire ihm_pkg::req_type req_data,
   output logic rsp_valid,
   input wire rsp_ready,
   output ihm_pkg::rsp_type rsp_data,
   input wire csr_psel,
   input wire csr_penable,
   input wire csr_pwrite,
   input wire [ihm_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input wire [ihm_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ihm_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);

   localparam int FW = ihm_pkg::FIELD_W;
   localparam int CW = ihm_pkg::COUNT_W;
   localparam int DW = ihm_pkg::CSR_DATA_W;
   localparam int KW = (KEY_BITS < FW) ? KEY_BITS : FW;
   localparam int MEM_W = 2 * KW;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int BIT_W = $clog2(KW);
   localparam bit IS_POW2 = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_DEPTH - 1);
   localparam logic [CNT_W-1:0] LOAD_LIM = CNT_W'(TABLE_DEPTH / 4 + 1);
   localparam logic [IDX_W:0] DEPTH_REM = (IDX_W + 1)'(TABLE_DEPTH);
   localparam logic [BIT_W-1:0] TOP_BIT = BIT_W'(KW - 1);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_HASH = 3'd2;
   localparam logic [2:0] S_PROBE = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [ihm_pkg::SHIFT_W-1:0] shift_ff, shift_in;
   logic [ihm_pkg::OP_W-1:0] op_ff, op_in;
   logic [KW-1:0] key_ff, key_in;
   logic [KW-1:0] val_ff, val_in;
   logic [KW-1:0] rem_src_ff, rem_src_in;
   logic [IDX_W:0] rem_ff, rem_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   logic [IDX_W-1:0] iss_slot_ff, iss_slot_in;
   logic [CNT_W-1:0] iss_cnt_ff, iss_cnt_in;
   logic cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0] cmp_slot_ff, cmp_slot_in;
   logic [CNT_W-1:0] chk_cnt_ff, chk_cnt_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [ihm_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [KW-1:0] res_data_ff, res_data_in;
   logic rsp_valid_ff, rsp_valid_in;
   ihm_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Table RAM: each entry holds the key in the upper half and the value in the lower half.
   logic [MEM_W-1:0] mem [TABLE_DEPTH];
   logic [MEM_W-1:0] rd_data_ff;
   logic mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [MEM_W-1:0] mem_wdata;

   logic req_fire;
   logic csr_write;
   logic [KW-1:0] key_m;
   logic [KW-1:0] val_m;
   logic [KW-1:0] shifted;
   logic [IDX_W:0] rem_step;
   logic [IDX_W:0] rem_fixed;
   logic [IDX_W-1:0] next_slot;
   logic [KW-1:0] rd_key;
   logic [KW-1:0] rd_val;
   logic [CNT_W-1:0] free_slots;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // Configuration port: single register, no wait states.
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == ihm_pkg::REG_HASH_SHIFT) ? DW'(shift_ff) : '0;

   always_comb begin
      shift_in = shift_ff;
      if (csr_write && (csr_paddr[2] == ihm_pkg::REG_HASH_SHIFT)) begin
         shift_in = csr_pwdata[ihm_pkg::SHIFT_W-1:0];
      end
   end

   // Datapath helpers.
   assign key_m = req_data.key[KW-1:0];
   assign val_m = req_data.value[KW-1:0];
   assign shifted = key_m >> shift_ff;
   assign rem_step = {rem_ff[IDX_W-1:0], rem_src_ff[bit_ff]};
   assign rem_fixed = (rem_step >= DEPTH_REM) ? (rem_step - DEPTH_REM) : rem_step;
   assign next_slot = (iss_slot_ff == LAST_SLOT) ? '0 : iss_slot_ff + 1'b1;
   assign rd_key = rd_data_ff[MEM_W-1:KW];
   assign rd_val = rd_data_ff[KW-1:0];
   assign free_slots = DEPTH_CNT - count_ff;

   // Sequencer: clear, hash, probe, and hand over the result.
   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      key_in = key_ff;
      val_in = val_ff;
      rem_src_in = rem_src_ff;
      rem_in = rem_ff;
      bit_in = bit_ff;
      iss_slot_in = iss_slot_ff;
      iss_cnt_in = iss_cnt_ff;
      cmp_vld_in = 1'b0;
      cmp_slot_in = cmp_slot_ff;
      chk_cnt_in = chk_cnt_ff;
      count_in = count_ff;
      res_status_in = res_status_ff;
      res_data_in = res_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      mem_we = 1'b0;
      mem_waddr = cmp_slot_ff;
      mem_wdata = {key_ff, val_ff};

      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_waddr = iss_slot_ff;
            mem_wdata = '0;
            if (iss_slot_ff == LAST_SLOT) begin
               iss_slot_in = '0;
               state_in = S_IDLE;
            end else begin
               iss_slot_in = iss_slot_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (req_fire) begin
               op_in = req_data.operation;
               key_in = key_m;
               val_in = val_m;
               iss_cnt_in = '0;
               chk_cnt_in = '0;
               if (((req_data.operation == ihm_pkg::OP_LOOKUP) ||
                    (req_data.operation == ihm_pkg::OP_SET)) && (key_m != '0)) begin
                  if (IS_POW2) begin
                     iss_slot_in = shifted[IDX_W-1:0];
                     state_in = S_PROBE;
                  end else begin
                     rem_src_in = shifted;
                     rem_in = '0;
                     bit_in = TOP_BIT;
                     state_in = S_HASH;
                  end
               end else if (req_data.operation == ihm_pkg::OP_SEARCH) begin
                  iss_slot_in = '0;
                  state_in = S_PROBE;
               end else begin
                  res_status_in = ihm_pkg::ST_FAIL;
                  res_data_in = '0;
                  state_in = S_FINISH;
               end
            end
         end

         // Restoring remainder of the shifted key, most significant bit first.
         S_HASH: begin
            rem_in = rem_fixed;
            if (bit_ff == '0) begin
               iss_slot_in = rem_fixed[IDX_W-1:0];
               state_in = S_PROBE;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end

         // Reads run one slot ahead of the compare; reads past a hit are dropped.
         S_PROBE: begin
            if (iss_cnt_ff != DEPTH_CNT) begin
               iss_slot_in = next_slot;
               iss_cnt_in = iss_cnt_ff + 1'b1;
               cmp_vld_in = 1'b1;
               cmp_slot_in = iss_slot_ff;
            end
            if (cmp_vld_ff) begin
               chk_cnt_in = chk_cnt_ff + 1'b1;
               case (op_ff)
                  ihm_pkg::OP_LOOKUP: begin
                     if (rd_key == key_ff) begin
                        res_status_in = ihm_pkg::ST_FOUND;
                        res_data_in = rd_val;
                        state_in = S_FINISH;
                     end else if (chk_cnt_ff == LAST_CNT) begin
                        res_status_in = ihm_pkg::ST_NOT_FOUND;
                        res_data_in = '0;
                        state_in = S_FINISH;
                     end
                  end
                  ihm_pkg::OP_SET: begin
                     if (rd_key == '0) begin
                        mem_we = 1'b1;
                        count_in = count_ff + 1'b1;
                        res_status_in = ihm_pkg::ST_INSERTED;
                        res_data_in = '0;
                        state_in = S_FINISH;
                     end else if (rd_key == key_ff) begin
                        mem_we = 1'b1;
                        res_status_in = ihm_pkg::ST_UPDATED;
                        res_data_in = '0;
                        state_in = S_FINISH;
                     end else if (chk_cnt_ff == LAST_CNT) begin
                        res_status_in = ihm_pkg::ST_FAIL;
                        res_data_in = '0;
                        state_in = S_FINISH;
                     end
                  end
                  ihm_pkg::OP_SEARCH: begin
                     if ((rd_key != '0) && (rd_val == val_ff)) begin
                        res_status_in = ihm_pkg::ST_FOUND;
                        res_data_in = rd_key;
                        state_in = S_FINISH;
                     end else if (chk_cnt_ff == LAST_CNT) begin
                        res_status_in = ihm_pkg::ST_NOT_FOUND;
                        res_data_in = '0;
                        state_in = S_FINISH;
                     end
                  end
                  default: begin
                     res_status_in = ihm_pkg::ST_FAIL;
                     res_data_in = '0;
                     state_in = S_FINISH;
                  end
               endcase
               if (state_in == S_FINISH) begin
                  cmp_vld_in = 1'b0;
               end
            end
         end

         // Load the output register once it is free.
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.status = res_status_ff;
               rsp_data_in.result_data = FW'(res_data_ff);
               rsp_data_in.entry_count = CW'(count_ff);
               rsp_data_in.load_high = (free_slots < LOAD_LIM);
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         shift_ff <= ihm_pkg::HASH_SHIFT_RESET;
         iss_slot_ff <= '0;
         iss_cnt_ff <= '0;
         cmp_vld_ff <= 1'b0;
         chk_cnt_ff <= '0;
         count_ff <= '0;
         bit_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         shift_ff <= shift_in;
         iss_slot_ff <= iss_slot_in;
         iss_cnt_ff <= iss_cnt_in;
         cmp_vld_ff <= cmp_vld_in;
         chk_cnt_ff <= chk_cnt_in;
         count_ff <= count_in;
         bit_ff <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff <= op_in;
      key_ff <= key_in;
      val_ff <= val_in;
      rem_src_ff <= rem_src_in;
      rem_ff <= rem_in;
      cmp_slot_ff <= cmp_slot_in;
      res_status_ff <= res_status_in;
      res_data_ff <= res_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Table RAM with one write port and a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[iss_slot_ff];
   end

endmodule
`default_nettype wire

/* design/ihm_checker.sv */
`default_nettype none
module ihm_checker (
   input wire clock,
   input wire reset,
   input wire req_valid,
   input wire req_ready,
   input wire ihm_pkg::req_type req_data,
   input wire rsp_valid,
   input wire rsp_ready,
   input wire ihm_pkg::rsp_type rsp_data
);

   // A stalled result word holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // Only lookups and searches that hit carry data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ihm_pkg::ST_FOUND) |-> rsp_data.result_data == '0)
      else $error("result data set on a word that found nothing");

   // An insert leaves at least one occupied slot.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ihm_pkg::ST_INSERTED) |-> rsp_data.entry_count != '0)
      else $error("insert reported with an empty table");

   // When no result is pending, none is presented in the cycle right after a word is taken in.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result appeared too early after a request");

   // A rejected zero key on lookup or set reports failure.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.key == '0) &&
      ((req_data.operation == ihm_pkg::OP_LOOKUP) || (req_data.operation == ihm_pkg::OP_SET))
      && (!rsp_valid || rsp_ready)
      |=> ##1 rsp_valid && (rsp_data.status == ihm_pkg::ST_FAIL))
      else $error("zero key not rejected");

endmodule

bind identity_hash_map_linear_probe ihm_checker u_ihm_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_data(req_data),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data(rsp_data)
);
`default_nettype wire
